// ----- src/rpt_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rpt_pkg: ranked population table shared definitions
// Field widths, operation and status codes, request and response types.
// ----------------------------------------------------------------------------
package rpt_pkg;

  localparam int FIT_W          = 32;
  localparam int ID_W           = 16;
  localparam int POS_W          = 8;
  localparam int RAND_W         = 16;
  localparam int RANK_W         = 8;
  localparam int CFG_W          = 9;
  localparam int OP_W           = 2;
  localparam int STAT_W         = 2;
  localparam int POP_DEPTH_DEF  = 256;
  localparam int POP_SIZE_RESET = 256;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_SELECT = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  localparam logic [STAT_W-1:0] STAT_DONE   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_REJECT = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY  = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [FIT_W-1:0]  new_fitness;
    logic [ID_W-1:0]   new_member_id;
    logic [RAND_W-1:0] random_fraction;
    logic [RANK_W-1:0] rank_index;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [POS_W-1:0]  position;
    logic [ID_W-1:0]   member_id_out;
    logic [FIT_W-1:0]  fitness_out;
    logic              evicted;
  } rsp_t;

  typedef struct packed {
    logic [FIT_W-1:0] fitness;
    logic [ID_W-1:0]  member_id;
  } entry_t;

endpackage
`default_nettype wire

// ----- src/ranked_population_table_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ranked_population_table_top: sorted population store with roulette select
// Keeps members sorted by descending fitness in one RAM, with a running total;
// insert with replace-worst, roulette-wheel select and read by rank.
// ----------------------------------------------------------------------------
//  channel  signals                      role
//  req      req_valid/req_ready/req      request in: operation and operands
//  rsp      rsp_valid/rsp_ready/rsp      one response per request
//  cfg      cfg_wr_en/cfg_wr_data        population size, no wait
//
//  insert: entries compared from the worst upward, lower ones shifted down; rejected if full and not above the worst
//  select: multiply, then prefix sum walked from best to the selected rank
//  read: one RAM port pair walks one entry per cycle, read registered
//  a size write below the fill count, when idle or trimming, starts a recompute of the total
//  reset clears control state only; table contents stay undefined until written
//  rsp stall holds the response register; the next request is still taken

module ranked_population_table_top #(
  parameter int POP_DEPTH = rpt_pkg::POP_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [rpt_pkg::CFG_W-1:0] cfg_wr_data,
  input  logic                      req_valid,
  output logic                      req_ready,
  input  rpt_pkg::req_t             req,
  output logic                      rsp_valid,
  input  logic                      rsp_ready,
  output rpt_pkg::rsp_t             rsp
);

  import rpt_pkg::*;

  localparam int AW        = $clog2(POP_DEPTH);
  localparam int CNT_W     = $clog2(POP_DEPTH + 1);
  localparam int CW        = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int RW        = (CNT_W > RANK_W) ? CNT_W : RANK_W;
  localparam int TOT_W     = FIT_W + AW;
  localparam int PROD_W    = TOT_W + RAND_W;
  localparam int RESET_CAP = (POP_DEPTH < POP_SIZE_RESET) ? POP_DEPTH : POP_SIZE_RESET;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_SCAN,
    ST_INS_PUT,
    ST_SEL_MUL,
    ST_SEL_SCAN,
    ST_RD_OUT,
    ST_TRIM_ISSUE,
    ST_TRIM_ACC,
    ST_POST
  } state_t;

  state_t              state;
  req_t                req_q;
  rsp_t                res;
  rsp_t                res_init;
  logic                full;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    cap;
  logic [TOT_W-1:0]    total;
  logic [TOT_W-1:0]    prefix;
  logic [PROD_W-1:0]   prod;
  logic [AW-1:0]       k;
  logic [AW-1:0]       pos;

  entry_t              mem [POP_DEPTH];
  entry_t              rd_q;
  logic [AW-1:0]       rd_addr;
  logic                mem_we;
  logic [AW-1:0]       wr_addr;
  entry_t              wr_data;

  logic [CW-1:0]       cfg_wide;
  logic [CW-1:0]       cap_wide;
  logic [CNT_W-1:0]    cap_new;
  logic                cut;
  logic [AW-1:0]       last;
  logic                drop;
  logic                gt;
  logic [TOT_W-1:0]    psum;
  logic                sel_hit;
  logic                rank_over;

  // capacity clamp
  always_comb begin
    cfg_wide = CW'(cfg_wr_data);
    if (cfg_wide < CW'(2)) begin
      cap_wide = CW'(2);
    end else if (cfg_wide > CW'(POP_DEPTH)) begin
      cap_wide = CW'(POP_DEPTH);
    end else begin
      cap_wide = cfg_wide;
    end
    cap_new = CNT_W'(cap_wide);
    cut     = cfg_wr_en && (count > cap_new);
  end

  assign last      = AW'(count - 1'b1);
  assign drop      = full && (k == last);
  assign gt        = req_q.new_fitness > rd_q.fitness;
  assign psum      = prefix + TOT_W'(rd_q.fitness);
  assign sel_hit   = {psum, {RAND_W{1'b0}}} >= prod;
  assign rank_over = RW'(req.rank_index) >= RW'(count);
  assign req_ready = (state == ST_IDLE) && !cfg_wr_en;

  // response start value for an accepted request
  always_comb begin
    res_init        = '0;
    res_init.status = (((req.operation == OP_SELECT) && (count == '0)) ||
                       ((req.operation == OP_READ) && rank_over)) ? STAT_EMPTY : STAT_DONE;
  end

  always_comb begin
    unique case (state)
      ST_IDLE:     rd_addr = (req.operation == OP_READ) ? AW'(req.rank_index) : last;
      ST_INS_SCAN: rd_addr = AW'(k - 1'b1);
      ST_SEL_SCAN: rd_addr = AW'(k + 1'b1);
      ST_TRIM_ACC: rd_addr = AW'(k + 1'b1);
      default:     rd_addr = k;
    endcase
  end

  always_comb begin
    mem_we  = 1'b0;
    wr_addr = pos;
    wr_data = {req_q.new_fitness, req_q.new_member_id};
    if (state == ST_INS_SCAN && gt && !drop) begin
      mem_we  = 1'b1;
      wr_addr = AW'(k + 1'b1);
      wr_data = rd_q;
    end else if (state == ST_INS_PUT) begin
      mem_we  = 1'b1;
    end
  end

  // table ram
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      total     <= '0;
      cap       <= CNT_W'(RESET_CAP);
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready && (state != ST_POST)) begin
        rsp_valid <= 1'b0;
      end
      if (cfg_wr_en) begin
        cap <= cap_new;
      end
      unique case (state)
        ST_IDLE: begin
          if (cut) begin
            count  <= cap_new;
            k      <= '0;
            prefix <= '0;
            state  <= ST_TRIM_ISSUE;
          end else if (req_valid && req_ready) begin
            req_q  <= req;
            full   <= (count >= cap);
            res    <= res_init;
            k      <= (req.operation == OP_SELECT) ? '0 :
                      (req.operation == OP_READ) ? AW'(req.rank_index) : last;
            pos    <= '0;
            prefix <= '0;
            unique case (req.operation)
              OP_INSERT: state <= (count == '0) ? ST_INS_PUT : ST_INS_SCAN;
              OP_SELECT: state <= (count == '0) ? ST_POST : ST_SEL_MUL;
              OP_READ:   state <= rank_over ? ST_POST : ST_RD_OUT;
              default:   state <= ST_POST;
            endcase
          end
        end
        ST_INS_SCAN: begin
          if (gt) begin
            if (drop) begin
              res.member_id_out <= rd_q.member_id;
              res.fitness_out   <= rd_q.fitness;
              res.evicted       <= 1'b1;
              total             <= total - TOT_W'(rd_q.fitness);
            end
            if (k == '0) begin
              pos   <= '0;
              state <= ST_INS_PUT;
            end else begin
              k <= k - 1'b1;
            end
          end else if (drop) begin
            res.status <= STAT_REJECT;
            state      <= ST_POST;
          end else begin
            pos   <= AW'(k + 1'b1);
            state <= ST_INS_PUT;
          end
        end
        ST_INS_PUT: begin
          total        <= total + TOT_W'(req_q.new_fitness);
          res.position <= POS_W'(pos);
          if (!full) begin
            count <= count + 1'b1;
          end
          state <= ST_POST;
        end
        ST_SEL_MUL: begin
          prod  <= PROD_W'(req_q.random_fraction) * PROD_W'(total);
          state <= ST_SEL_SCAN;
        end
        ST_SEL_SCAN: begin
          if (sel_hit || k == last) begin
            res.position      <= POS_W'(k);
            res.member_id_out <= rd_q.member_id;
            res.fitness_out   <= rd_q.fitness;
            state             <= ST_POST;
          end else begin
            prefix <= psum;
            k      <= k + 1'b1;
          end
        end
        ST_RD_OUT: begin
          res.position      <= POS_W'(k);
          res.member_id_out <= rd_q.member_id;
          res.fitness_out   <= rd_q.fitness;
          state             <= ST_POST;
        end
        ST_TRIM_ISSUE: begin
          if (cut) begin
            count  <= cap_new;
            k      <= '0;
            prefix <= '0;
          end else begin
            state <= ST_TRIM_ACC;
          end
        end
        ST_TRIM_ACC: begin
          if (cut) begin
            count  <= cap_new;
            k      <= '0;
            prefix <= '0;
            state  <= ST_TRIM_ISSUE;
          end else if (k == last) begin
            total <= psum;
            state <= ST_IDLE;
          end else begin
            prefix <= psum;
            k      <= k + 1'b1;
          end
        end
        ST_POST: begin
          if (!rsp_valid || rsp_ready) begin
            rsp       <= res;
            rsp_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (wr_addr <= count))
    else $error("table write beyond fill count");

  a_fill_grows: assert property (@(posedge clk) disable iff (rst)
    (state == ST_INS_PUT) && !full |=> (count == CNT_W'($past(count) + 1'b1)))
    else $error("fill count not advanced on insert");

  a_select_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEL_SCAN) |-> (k < count))
    else $error("select walked past fill count");

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: ranked population table testbench
// Drives insert, roulette select and read requests through the valid/ready
// request channel, mirrors the sorted table, its fitness total and the
// population size in a local model, and checks every response in order.
// Directed tests cover the empty table, ties, replace-worst, rejects,
// roulette extremes and size clamping/cutting; random phases follow.
// ----------------------------------------------------------------------------
module tb_top;
  import rpt_pkg::*;

  localparam logic [OP_W-1:0] OP_NOP = 2'd3;
  localparam int DEPTH = POP_DEPTH_DEF;
  localparam int IDLE_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 8;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [CFG_W-1:0] cfg_wr_data = '0;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  // mirror of the table
  logic [FIT_W-1:0] mirror_fit [DEPTH];
  logic [ID_W-1:0] mirror_id [DEPTH];
  int unsigned mirror_fill = 0;
  logic [39:0] mirror_total = '0;
  int unsigned mirror_cap = POP_SIZE_RESET;

  rsp_t outcome_q [$];
  rsp_t want_rsp;

  int mismatch_count = 0;
  int rsp_seen = 0;
  int insert_cnt = 0;
  int select_cnt = 0;
  int read_cnt = 0;
  int evict_cnt = 0;
  int reject_cnt = 0;
  int size_writes = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  bit steady = 1'b0;

  logic [31:0] stall_pat = 32'hFFFF_FFFF;
  int pat_age = 0;

  ranked_population_table_top u_top (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  always #5 clk = ~clk;

  function automatic void apply_pop_size(logic [CFG_W-1:0] v);
    int unsigned k;
    mirror_cap = v;
    if (mirror_cap < 2) mirror_cap = 2;
    if (mirror_cap > DEPTH) mirror_cap = DEPTH;
    if (mirror_fill > mirror_cap) begin
      mirror_fill = mirror_cap;
      mirror_total = '0;
      for (k = 0; k < mirror_cap; k++) mirror_total += mirror_fit[k];
    end
  endfunction

  function automatic rsp_t apply_table_op(req_t r);
    rsp_t o;
    int unsigned p, k, n, last;
    logic [63:0] frac, quo, rem, thr, prefix;
    o = '0;
    n = mirror_fill;
    case (r.operation)
      OP_INSERT: begin
        insert_cnt++;
        p = 0;
        while (p < n && mirror_fit[p] >= r.new_fitness) p++;
        if (n >= mirror_cap && p >= n) begin
          o.status = STAT_REJECT;
          reject_cnt++;
        end else begin
          if (n >= mirror_cap) begin
            last = n - 1;
            o.member_id_out = mirror_id[last];
            o.fitness_out = mirror_fit[last];
            o.evicted = 1'b1;
            mirror_total -= mirror_fit[last];
            evict_cnt++;
          end else begin
            last = n;
            mirror_fill = n + 1;
          end
          for (k = last; k > p; k--) begin
            mirror_fit[k] = mirror_fit[k-1];
            mirror_id[k] = mirror_id[k-1];
          end
          mirror_fit[p] = r.new_fitness;
          mirror_id[p] = r.new_member_id;
          mirror_total += r.new_fitness;
          o.status = STAT_DONE;
          o.position = p[POS_W-1:0];
        end
      end
      OP_SELECT: begin
        select_cnt++;
        if (n == 0) begin
          o.status = STAT_EMPTY;
        end else begin
          frac = r.random_fraction;
          quo = mirror_total >> 16;
          rem = mirror_total & 40'hFFFF;
          thr = frac * quo + ((frac * rem + 64'hFFFF) >> 16);
          prefix = '0;
          for (k = 0; k < n; k++) begin
            prefix += mirror_fit[k];
            if (prefix >= thr) break;
          end
          if (k >= n) k = n - 1;
          o.position = k[POS_W-1:0];
          o.member_id_out = mirror_id[k];
          o.fitness_out = mirror_fit[k];
        end
      end
      OP_READ: begin
        read_cnt++;
        if (r.rank_index >= n) begin
          o.status = STAT_EMPTY;
        end else begin
          o.position = r.rank_index;
          o.member_id_out = mirror_id[r.rank_index];
          o.fitness_out = mirror_fit[r.rank_index];
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic req_t make_insert(logic [FIT_W-1:0] fit, logic [ID_W-1:0] id);
    req_t r;
    r = '0;
    r.operation = OP_INSERT;
    r.new_fitness = fit;
    r.new_member_id = id;
    return r;
  endfunction

  function automatic req_t make_select(logic [RAND_W-1:0] frac);
    req_t r;
    r = '0;
    r.operation = OP_SELECT;
    r.random_fraction = frac;
    return r;
  endfunction

  function automatic req_t make_read(logic [RANK_W-1:0] rank);
    req_t r;
    r = '0;
    r.operation = OP_READ;
    r.rank_index = rank;
    return r;
  endfunction

  function automatic req_t random_request(int insert_pct);
    req_t r;
    int pick;
    r.operation = OP_NOP;
    r.new_fitness = $urandom;
    r.new_member_id = ID_W'($urandom);
    r.random_fraction = RAND_W'($urandom);
    r.rank_index = RANK_W'($urandom);
    // noise: any opcode, any rank
    if ($urandom_range(0, 99) < 8) begin
      r.operation = OP_W'($urandom);
      return r;
    end
    pick = $urandom_range(0, 99);
    if (pick < insert_pct) begin
      r.operation = OP_INSERT;
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        r.new_fitness = $urandom_range(0, 15);
      end else if (pick < 30) begin
        r.new_fitness = '0;
      end else if (pick < 35) begin
        r.new_fitness = '1;
      end else if (pick < 42 && mirror_fill > 0) begin
        r.new_fitness = mirror_fit[mirror_fill-1] + $urandom_range(0, 1);
      end
    end else if (pick < insert_pct + (100 - insert_pct) / 2) begin
      r.operation = OP_SELECT;
      if ($urandom_range(0, 9) == 0) r.random_fraction = $urandom_range(0, 1) ? '1 : '0;
    end else begin
      r.operation = OP_READ;
      if (mirror_fill > 0 && $urandom_range(0, 9) < 8)
        r.rank_index = RANK_W'($urandom_range(0, mirror_fill - 1));
    end
    return r;
  endfunction

  // sender: bursts with random gaps, valid held across back-to-back requests
  task automatic issue_request(req_t r);
    int gap;
    if (burst_left == 0) begin
      if (steady) gap = 0;
      else if ($urandom_range(0, 3) == 0) gap = $urandom_range(5, 25);
      else gap = $urandom_range(0, 4);
      burst_left = $urandom_range(1, 30);
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    outcome_q.push_back(apply_table_op(r));
  endtask

  task automatic wait_drain();
    req_valid <= 1'b0;
    do @(posedge clk); while (outcome_q.size() != 0);
  endtask

  task automatic write_pop_size(logic [CFG_W-1:0] v);
    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    apply_pop_size(v);
    size_writes++;
  endtask

  task automatic test_empty_table();
    req_t r;
    issue_request(make_select('1));
    issue_request(make_read('0));
    r = '1;
    r.operation = OP_NOP;
    issue_request(r);
    // zero total fitness selects rank 0
    issue_request(make_insert('0, 16'h0001));
    issue_request(make_select('1));
  endtask

  task automatic test_sorted_fill();
    write_pop_size(9'd4);
    issue_request(make_insert('1, '1));
    issue_request(make_insert(32'd100, 16'h0002));
    issue_request(make_insert(32'd100, 16'h0003));
    issue_request(make_read('1));
    issue_request(make_read(8'd3));
  endtask

  task automatic test_replace_worst();
    issue_request(make_insert('0, '0));
    issue_request(make_insert(32'd50, 16'h0007));
    issue_request(make_insert(32'd100, 16'h0009));
    issue_request(make_insert('1, 16'h0005));
  endtask

  task automatic test_roulette();
    issue_request(make_select('0));
    issue_request(make_select('1));
    issue_request(make_select(16'h8000));
  endtask

  task automatic test_size_clamp_cut();
    write_pop_size(9'd0);
    issue_request(make_read(8'd1));
    issue_request(make_read(8'd2));
    write_pop_size('1);
    issue_request(make_insert(32'h0000_8000, 16'hA5A5));
  endtask

  task automatic test_random_mix();
    int sizes [7] = '{12, 3, 511, 0, 40, 7, 130};
    int counts [7] = '{120, 80, 300, 60, 150, 100, 90};
    int i, j, pct;
    for (i = 0; i < 7; i++) begin
      write_pop_size(CFG_W'(sizes[i]));
      steady = ($urandom_range(0, 3) == 0);
      pct = (sizes[i] == 511) ? 90 : 55;
      for (j = 0; j < counts[i]; j++) begin
        if (j % 100 == 99) steady = ~steady;
        if ($urandom_range(0, 59) == 0) wait_drain();
        issue_request(random_request(pct));
      end
    end
  endtask

  task automatic check_field(string name, logic [FIT_W-1:0] want, logic [FIT_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch expected %0h actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // response checker
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      rsp_seen++;
      if (outcome_q.size() == 0) begin
        $display("%0t: unexpected response expected none actual %0h", $time, rsp);
        mismatch_count++;
      end else begin
        want_rsp = outcome_q.pop_front();
        check_field("status", want_rsp.status, rsp.status);
        check_field("position", want_rsp.position, rsp.position);
        check_field("member_id_out", want_rsp.member_id_out, rsp.member_id_out);
        check_field("fitness_out", want_rsp.fitness_out, rsp.fitness_out);
        check_field("evicted", want_rsp.evicted, rsp.evicted);
      end
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    rsp_ready <= stall_pat[0];
    if (pat_age == 63) begin
      pat_age <= 0;
      case ($urandom_range(0, 3))
        0: stall_pat <= '1;
        1: stall_pat <= $urandom;
        2: stall_pat <= $urandom & $urandom;
        default: stall_pat <= 32'h0000_FFFF;
      endcase
    end else begin
      pat_age <= pat_age + 1;
      stall_pat <= {stall_pat[0], stall_pat[31:1]};
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready) || cfg_wr_en) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    for (int k = 0; k < DEPTH; k++) begin
      mirror_fit[k] = '0;
      mirror_id[k] = '0;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_table();
    test_sorted_fill();
    test_replace_worst();
    test_roulette();
    test_size_clamp_cut();
    test_random_mix();
    wait_drain();
    repeat (300) @(posedge clk);
    $display("covered %0d inserts (%0d evictions, %0d rejects), %0d selects, %0d reads",
             insert_cnt, evict_cnt, reject_cnt, select_cnt, read_cnt);
    $display("%0d responses checked across %0d population size writes", rsp_seen, size_writes);
    if (mismatch_count == 0 && outcome_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
